// ===== sv/per_connection_frame_deframer_assert.svh =====
// assertion macros shared by the deframer checker
// depends on nothing; included by bare file name
`ifndef PER_CONNECTION_FRAME_DEFRAMER_ASSERT_SVH
`define PER_CONNECTION_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, held off while in reset
`define PCFD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pcfd check failed");

// next-cycle implication, held off while in reset
`define PCFD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pcfd check failed");

`endif

// ===== sv/pcfd_pkg.sv =====
// shared widths, codes and types of the per-connection deframer
// depends on nothing
package pcfd_pkg;

	localparam int NUM_CONNECTIONS_DEF = 1024;
	localparam int HEADER_BYTES        = 8;
	localparam int QUEUE_DEPTH         = 4;

	localparam int OP_W       = 3;
	localparam int CONN_W     = 10;
	localparam int TAG_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int WORD_W     = 32;
	localparam int SRC_W      = 4;
	localparam int HDR_CNT_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [OP_W-1:0] OP_OPEN       = 3'd0;
	localparam logic [OP_W-1:0] OP_READ       = 3'd1;
	localparam logic [OP_W-1:0] OP_EOF        = 3'd2;
	localparam logic [OP_W-1:0] OP_ERROR      = 3'd3;
	localparam logic [OP_W-1:0] OP_CONNECTING = 3'd4;
	localparam logic [OP_W-1:0] OP_CONNECTED  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_PAYLOAD   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_VIOLATION = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROCESSOR_ID = 2'd1;

	localparam logic [WORD_W-1:0] FRAME_LIMIT_RST  = 32'd65528;
	localparam logic [SRC_W-1:0]  PROCESSOR_ID_RST = 4'd0;

	typedef enum logic [2:0] {
		CLS_OPEN,
		CLS_CONNECTING,
		CLS_CONNECTED,
		CLS_CLOSE,
		CLS_READ,
		CLS_BAD
	} evt_class_t;

	typedef struct packed {
		evt_class_t          cls;
		logic [CONN_W-1:0]   conn_id;
		logic [TAG_W-1:0]    tag;
		logic [BYTE_W-1:0]   data;
	} qitem_t;

endpackage

// ===== sv/pcfd_if.sv =====
// event, result and configuration channels of the deframer
// depends on pcfd_pkg
interface pcfd_evt_if;
	logic                          valid;
	logic                          ready;
	logic [pcfd_pkg::OP_W-1:0]     operation;
	logic [pcfd_pkg::CONN_W-1:0]   conn_id;
	logic [pcfd_pkg::TAG_W-1:0]    conn_tag;
	logic [pcfd_pkg::BYTE_W-1:0]   data_byte;

	modport source(output valid, operation, conn_id, conn_tag, data_byte, input ready);
	modport sink(input valid, operation, conn_id, conn_tag, data_byte, output ready);
endinterface

interface pcfd_res_if;
	logic                          valid;
	logic                          ready;
	logic [pcfd_pkg::STATUS_W-1:0] status;
	logic [pcfd_pkg::CONN_W-1:0]   out_conn_id;
	logic [pcfd_pkg::TAG_W-1:0]    out_tag;
	logic [pcfd_pkg::WORD_W-1:0]   channel;
	logic [pcfd_pkg::WORD_W-1:0]   frame_length;
	logic [pcfd_pkg::BYTE_W-1:0]   payload_byte;
	logic                          first_of_frame;
	logic                          last_of_frame;
	logic [pcfd_pkg::SRC_W-1:0]    source_id;

	modport source(output valid, status, out_conn_id, out_tag, channel, frame_length,
		payload_byte, first_of_frame, last_of_frame, source_id, input ready);
	modport sink(input valid, status, out_conn_id, out_tag, channel, frame_length,
		payload_byte, first_of_frame, last_of_frame, source_id, output ready);
endinterface

interface pcfd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pcfd_pkg::CFG_IDX_W-1:0]  index;
	logic [pcfd_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/pcfd_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing; a read at the address being written returns the old data
module pcfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/pcfd_front.sv =====
// front end: takes event words, classifies them and queues them for the back end
// depends on pcfd_pkg and pcfd_if
module pcfd_front #(
	parameter int NUM_CONNECTIONS = pcfd_pkg::NUM_CONNECTIONS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	pcfd_evt_if.sink         evt,
	input  logic             clr_done,
	input  logic             pop,
	output logic             head_valid,
	output pcfd_pkg::qitem_t head
);

	localparam int DEPTH = pcfd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = 32;
	localparam int PAD_W = CMP_W - pcfd_pkg::CONN_W;

	pcfd_pkg::qitem_t     q_mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	pcfd_pkg::evt_class_t cls;
	pcfd_pkg::qitem_t     item;
	logic                 in_range;
	logic                 push;

	always_comb begin
		unique case (evt.operation) inside
			pcfd_pkg::OP_OPEN:                     cls = pcfd_pkg::CLS_OPEN;
			pcfd_pkg::OP_CONNECTING:               cls = pcfd_pkg::CLS_CONNECTING;
			pcfd_pkg::OP_CONNECTED:                cls = pcfd_pkg::CLS_CONNECTED;
			pcfd_pkg::OP_EOF, pcfd_pkg::OP_ERROR:  cls = pcfd_pkg::CLS_CLOSE;
			pcfd_pkg::OP_READ:                     cls = pcfd_pkg::CLS_READ;
			default:                               cls = pcfd_pkg::CLS_BAD;
		endcase
	end

	assign in_range     = {{PAD_W{1'b0}}, evt.conn_id} < CMP_W'(NUM_CONNECTIONS);
	assign item.cls     = cls;
	assign item.conn_id = evt.conn_id;
	assign item.tag     = evt.conn_tag;
	assign item.data    = evt.data_byte;

	assign evt.ready  = clr_done && (count_q != CNT_W'(DEPTH));
	// words for connections outside the table are taken and dropped
	assign push       = evt.valid && evt.ready && in_range;
	assign head_valid = count_q != '0;
	assign head       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

endmodule

// ===== sv/pcfd_back.sv =====
// back end: session table read-modify-write, header/payload decode, result register
// depends on pcfd_pkg, pcfd_if and pcfd_ram
module pcfd_back #(
	parameter int NUM_CONNECTIONS = pcfd_pkg::NUM_CONNECTIONS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  pcfd_pkg::qitem_t head,
	output logic             pop,
	output logic             clr_done,
	pcfd_res_if.source       res,
	pcfd_cfg_if.sink         cfg
);

	localparam int AW    = NUM_CONNECTIONS > 1 ? $clog2(NUM_CONNECTIONS) : 1;
	localparam int WW    = pcfd_pkg::WORD_W;
	localparam int BW    = pcfd_pkg::BYTE_W;
	localparam int HCW   = pcfd_pkg::HDR_CNT_W;
	localparam int PAD_W = 32 - pcfd_pkg::CONN_W;
	localparam logic [HCW-1:0] HDR_LAST  = HCW'(pcfd_pkg::HEADER_BYTES - 1);
	localparam logic [HCW-1:0] LEN_BYTES = HCW'(pcfd_pkg::HEADER_BYTES / 2);
	localparam logic [AW-1:0]  LAST_ADDR = AW'(NUM_CONNECTIONS - 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CONNECTING,
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		phase_t                        phase;
		logic [pcfd_pkg::TAG_W-1:0]    tag;
		logic [HCW-1:0]                hdr_cnt;
		logic [WW-1:0]                 len;
		logic [WW-1:0]                 chan;
		logic [WW-1:0]                 rem;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// configuration
	logic [WW-1:0]              frame_limit_q;
	logic [pcfd_pkg::SRC_W-1:0] processor_id_q;

	// clearing pass
	logic [AW-1:0]     clr_addr_q;
	logic              clr_done_q;

	// execute stage
	logic              s1_valid_q;
	pcfd_pkg::qitem_t  item_s1;
	logic              s1_fire;
	logic              s1_open;
	logic [AW-1:0]     s1_addr;
	logic [AW-1:0]     head_addr;

	// last table write, forwarded to the next word
	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	entry_t            fwd_data_q;

	// table port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	// decode
	entry_t            e;
	entry_t            ne;
	logic              busy;
	logic              match;
	logic [WW-1:0]     rem_dec;
	logic              r_has;
	logic              r_hdr;
	logic [pcfd_pkg::STATUS_W-1:0] r_status;
	logic [BW-1:0]     r_byte;
	logic              r_first;
	logic              r_last;

	// result register
	logic              res_valid_q;
	logic [pcfd_pkg::STATUS_W-1:0] status_q;
	logic [pcfd_pkg::CONN_W-1:0]   conn_id_q;
	logic [pcfd_pkg::TAG_W-1:0]    tag_q;
	logic [WW-1:0]     channel_q;
	logic [WW-1:0]     length_q;
	logic [BW-1:0]     byte_q;
	logic              first_q;
	logic              last_q;
	logic [pcfd_pkg::SRC_W-1:0]    source_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q  <= pcfd_pkg::FRAME_LIMIT_RST;
			processor_id_q <= pcfd_pkg::PROCESSOR_ID_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pcfd_pkg::CFG_FRAME_LIMIT:  frame_limit_q  <= cfg.data[WW-1:0];
				pcfd_pkg::CFG_PROCESSOR_ID: processor_id_q <= cfg.data[pcfd_pkg::SRC_W-1:0];
				default: ;
			endcase
		end
	end

	// after reset every entry is written idle, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_done_q <= 1'b1;
			end else begin
				clr_addr_q <= AW'(clr_addr_q + 1'b1);
			end
		end
	end

	assign clr_done  = clr_done_q;
	assign head_addr = AW'({{PAD_W{1'b0}}, head.conn_id});
	assign s1_addr   = AW'({{PAD_W{1'b0}}, item_s1.conn_id});
	assign s1_fire   = s1_valid_q && (!res_valid_q || res.ready);
	assign s1_open   = !s1_valid_q || s1_fire;
	assign pop       = head_valid && clr_done_q && s1_open;

	assign ram_we    = !clr_done_q || s1_fire;
	assign ram_waddr = clr_done_q ? s1_addr : clr_addr_q;
	assign ram_wdata = clr_done_q ? ENTRY_W'(ne) : '0;

	pcfd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_CONNECTIONS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop),
		.raddr(head_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (s1_open) begin
				s1_valid_q <= pop;
			end
			if (s1_fire) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
		end
		if (s1_fire) begin
			fwd_addr_q <= s1_addr;
			fwd_data_q <= ne;
		end
	end

	assign e       = (fwd_valid_q && fwd_addr_q == s1_addr) ? fwd_data_q : entry_t'(ram_rdata);
	assign busy    = e.phase != PH_IDLE;
	assign match   = busy && (e.tag == item_s1.tag);
	assign rem_dec = (e.rem == '0) ? '0 : e.rem - 1'b1;

	always_comb begin
		ne       = e;
		r_has    = 1'b0;
		r_hdr    = 1'b0;
		r_status = pcfd_pkg::ST_VIOLATION;
		r_byte   = '0;
		r_first  = 1'b0;
		r_last   = 1'b0;
		unique case (item_s1.cls) inside
			pcfd_pkg::CLS_OPEN, pcfd_pkg::CLS_CONNECTING: begin
				if (busy) begin
					r_has = 1'b1;
				end else begin
					ne.phase   = (item_s1.cls == pcfd_pkg::CLS_OPEN) ? PH_HEADER : PH_CONNECTING;
					ne.tag     = item_s1.tag;
					ne.hdr_cnt = '0;
					ne.len     = '0;
					ne.chan    = '0;
					ne.rem     = '0;
				end
			end
			pcfd_pkg::CLS_CONNECTED: begin
				if (e.phase != PH_CONNECTING || !match) begin
					r_has = 1'b1;
				end else begin
					ne.phase   = PH_HEADER;
					ne.hdr_cnt = '0;
				end
			end
			pcfd_pkg::CLS_CLOSE: begin
				r_has = 1'b1;
				if (match) begin
					ne.phase = PH_IDLE;
					r_status = pcfd_pkg::ST_CLOSED;
				end
			end
			pcfd_pkg::CLS_READ: begin
				// reads on idle entries, and tag-matching reads on connecting entries, are dropped silently
				if (busy && !match) begin
					r_has = 1'b1;
				end else if (busy && e.phase == PH_HEADER) begin
					if (e.hdr_cnt < LEN_BYTES) begin
						ne.len = {e.len[WW-BW-1:0], item_s1.data};
					end else begin
						ne.chan = {e.chan[WW-BW-1:0], item_s1.data};
					end
					if (e.hdr_cnt != HDR_LAST) begin
						ne.hdr_cnt = HCW'(e.hdr_cnt + 1'b1);
					end else begin
						ne.hdr_cnt = '0;
						if (e.len > frame_limit_q) begin
							ne.phase = PH_IDLE;
							r_has    = 1'b1;
							r_hdr    = 1'b1;
							r_status = pcfd_pkg::ST_TOO_LARGE;
						end else if (e.len == '0) begin
							r_has    = 1'b1;
							r_hdr    = 1'b1;
							r_last   = 1'b1;
							r_status = pcfd_pkg::ST_EMPTY;
						end else begin
							ne.rem   = e.len;
							ne.phase = PH_PAYLOAD;
						end
					end
				end else if (busy && e.phase == PH_PAYLOAD) begin
					r_has    = 1'b1;
					r_hdr    = 1'b1;
					r_status = pcfd_pkg::ST_PAYLOAD;
					r_byte   = item_s1.data;
					r_first  = e.rem == e.len;
					r_last   = e.rem[WW-1:1] == '0;
					ne.rem   = rem_dec;
					if (rem_dec == '0) begin
						ne.phase   = PH_HEADER;
						ne.hdr_cnt = '0;
					end
				end
			end
			default: begin
				r_has = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire) begin
			res_valid_q <= r_has;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && r_has) begin
			status_q  <= r_status;
			conn_id_q <= item_s1.conn_id;
			tag_q     <= busy ? e.tag : '0;
			channel_q <= r_hdr ? ne.chan : '0;
			length_q  <= r_hdr ? ne.len : '0;
			byte_q    <= r_byte;
			first_q   <= r_first;
			last_q    <= r_last;
			source_q  <= processor_id_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = status_q;
	assign res.out_conn_id    = conn_id_q;
	assign res.out_tag        = tag_q;
	assign res.channel        = channel_q;
	assign res.frame_length   = length_q;
	assign res.payload_byte   = byte_q;
	assign res.first_of_frame = first_q;
	assign res.last_of_frame  = last_q;
	assign res.source_id      = source_q;

endmodule

// ===== sv/per_connection_frame_deframer.sv =====
// per-connection length-prefixed frame deframer, top level
// an event word passes the front-end queue, the execute stage and the result register
// throughput: one event word per cycle while res.ready does not stall, set by the single
//   session-table read-modify-write, the last written entry forwarded to the next word
// reset: clears the control state, then writes every table entry idle with evt.ready low;
//   configuration writes are taken throughout
module per_connection_frame_deframer #(
	parameter int NUM_CONNECTIONS = pcfd_pkg::NUM_CONNECTIONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pcfd_evt_if.sink   evt,
	pcfd_res_if.source res,
	pcfd_cfg_if.sink   cfg
);

	logic             head_valid;
	pcfd_pkg::qitem_t head;
	logic             pop;
	logic             clr_done;

	pcfd_front #(
		.NUM_CONNECTIONS(NUM_CONNECTIONS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.clr_done  (clr_done),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	pcfd_back #(
		.NUM_CONNECTIONS(NUM_CONNECTIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.clr_done  (clr_done),
		.res       (res),
		.cfg       (cfg)
	);

endmodule

// ===== sv/pcfd_checker.sv =====
// port-level checks of the deframer, bound to the top level
// depends on pcfd_pkg and per_connection_frame_deframer_assert.svh
`include "per_connection_frame_deframer_assert.svh"

module pcfd_port_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          evt_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [pcfd_pkg::STATUS_W-1:0] res_status,
	input logic [pcfd_pkg::WORD_W-1:0]   res_channel,
	input logic [pcfd_pkg::WORD_W-1:0]   res_frame_length,
	input logic [pcfd_pkg::BYTE_W-1:0]   res_payload_byte,
	input logic                          res_first,
	input logic                          res_last
);

	// table clearing keeps event words out right after reset
	`PCFD_ASSERT_IMP(a_clear_blocks, clk, arst_n, !$past(arst_n), !evt_ready)

	`PCFD_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_channel) && $stable(res_frame_length))

	`PCFD_ASSERT_IMP(a_first_payload, clk, arst_n, res_valid && res_first, res_status == pcfd_pkg::ST_PAYLOAD && res_frame_length != '0)

	`PCFD_ASSERT_IMP(a_empty_frame, clk, arst_n, res_valid && res_status == pcfd_pkg::ST_EMPTY, res_last && res_frame_length == '0)

	`PCFD_ASSERT_IMP(a_no_header_info, clk, arst_n, res_valid && (res_status == pcfd_pkg::ST_CLOSED || res_status == pcfd_pkg::ST_VIOLATION), res_channel == '0 && res_frame_length == '0 && res_payload_byte == '0 && !res_first && !res_last)

endmodule

bind per_connection_frame_deframer pcfd_port_checker u_pcfd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.evt_ready       (evt.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_status      (res.status),
	.res_channel     (res.channel),
	.res_frame_length(res.frame_length),
	.res_payload_byte(res.payload_byte),
	.res_first       (res.first_of_frame),
	.res_last        (res.last_of_frame)
);

// ===== verif/pcfd_checker.sv =====
// deframer checker: watches the event, result and config channels, keeps its own
// session table and compares every result word with the predicted one
// depends on pcfd_pkg and the channel interfaces in pcfd_if.sv
`timescale 1ns / 100ps

module pcfd_checker import pcfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pcfd_evt_if  evt,
	pcfd_res_if  res,
	pcfd_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);

	localparam int NUM_CONN = NUM_CONNECTIONS_DEF;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONNECTING,
		S_HEADER,
		S_PAYLOAD
	} sess_phase_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CONN_W-1:0]   conn;
		logic [TAG_W-1:0]    tag;
		logic [WORD_W-1:0]   channel;
		logic [WORD_W-1:0]   length;
		logic [BYTE_W-1:0]   pbyte;
		logic                first;
		logic                last;
		logic [SRC_W-1:0]    src;
	} frame_word_t;

	sess_phase_t          phase_tbl  [NUM_CONN];
	logic [TAG_W-1:0]     tag_tbl    [NUM_CONN];
	logic [HDR_CNT_W-1:0] hdr_tbl    [NUM_CONN];
	logic [WORD_W-1:0]    len_tbl    [NUM_CONN];
	logic [WORD_W-1:0]    chan_tbl   [NUM_CONN];
	logic [WORD_W-1:0]    remain_tbl [NUM_CONN];
	logic [WORD_W-1:0]    frame_limit;
	logic [SRC_W-1:0]     proc_id;
	frame_word_t          awaited_words [$];

	// returns 1 when the event word produces a result word
	function automatic bit deframe_event(input logic [OP_W-1:0] op, input logic [CONN_W-1:0] c,
			input logic [TAG_W-1:0] t, input logic [BYTE_W-1:0] b, output frame_word_t w);
		sess_phase_t ph;
		logic busy;
		logic match;
		int n;
		logic [WORD_W-1:0] rem;
		ph = phase_tbl[c];
		busy = (ph != S_IDLE);
		match = busy && (tag_tbl[c] == t);
		w = '0;
		w.conn = c;
		w.src = proc_id;
		w.status = ST_VIOLATION;
		if (busy) w.tag = tag_tbl[c];
		case (op)
			OP_OPEN, OP_CONNECTING: begin
				if (busy) return 1'b1;
				phase_tbl[c] = (op == OP_OPEN) ? S_HEADER : S_CONNECTING;
				tag_tbl[c] = t;
				hdr_tbl[c] = '0;
				len_tbl[c] = '0;
				chan_tbl[c] = '0;
				remain_tbl[c] = '0;
				return 1'b0;
			end
			OP_CONNECTED: begin
				if (ph != S_CONNECTING || !match) return 1'b1;
				phase_tbl[c] = S_HEADER;
				hdr_tbl[c] = '0;
				return 1'b0;
			end
			OP_EOF, OP_ERROR: begin
				if (!match) return 1'b1;
				phase_tbl[c] = S_IDLE;
				w.status = ST_CLOSED;
				return 1'b1;
			end
			OP_READ: begin
				if (!busy) return 1'b0;
				if (!match) return 1'b1;
				if (ph == S_HEADER) begin
					n = int'(hdr_tbl[c]);
					if (n < 4) len_tbl[c] = {len_tbl[c][WORD_W-BYTE_W-1:0], b};
					else chan_tbl[c] = {chan_tbl[c][WORD_W-BYTE_W-1:0], b};
					if (n + 1 < HEADER_BYTES) begin
						hdr_tbl[c] = HDR_CNT_W'(n + 1);
						return 1'b0;
					end
					hdr_tbl[c] = '0;
					w.channel = chan_tbl[c];
					w.length = len_tbl[c];
					if (len_tbl[c] > frame_limit) begin
						phase_tbl[c] = S_IDLE;
						w.status = ST_TOO_LARGE;
						return 1'b1;
					end
					if (len_tbl[c] == '0) begin
						w.status = ST_EMPTY;
						w.last = 1'b1;
						return 1'b1;
					end
					remain_tbl[c] = len_tbl[c];
					phase_tbl[c] = S_PAYLOAD;
					return 1'b0;
				end
				if (ph == S_PAYLOAD) begin
					rem = remain_tbl[c];
					w.status = ST_PAYLOAD;
					w.channel = chan_tbl[c];
					w.length = len_tbl[c];
					w.pbyte = b;
					w.first = (rem == len_tbl[c]);
					w.last = (rem <= 1);
					rem = (rem == '0) ? '0 : rem - 1;
					remain_tbl[c] = rem;
					if (rem == '0) begin
						phase_tbl[c] = S_HEADER;
						hdr_tbl[c] = '0;
					end
					return 1'b1;
				end
				// connecting and tag matches: byte dropped
				return 1'b0;
			end
			default: return 1'b1;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [CONN_W-1:0] c,
			input logic [WORD_W-1:0] want, input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch on conn %0d, expected %h, actual %h",
				$time, name, c, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		frame_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_CONN; i++) phase_tbl[i] = S_IDLE;
			frame_limit = FRAME_LIMIT_RST;
			proc_id = PROCESSOR_ID_RST;
			awaited_words.delete();
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_FRAME_LIMIT: frame_limit = cfg.data;
					CFG_PROCESSOR_ID: proc_id = cfg.data[SRC_W-1:0];
					default: ;
				endcase
			end
			if (evt.valid && evt.ready) begin
				if (deframe_event(evt.operation, evt.conn_id, evt.conn_tag, evt.data_byte, want))
					awaited_words.push_back(want);
			end
			if (res.valid && res.ready) begin
				if (awaited_words.size() == 0) begin
					$display("%0t: unexpected result word, expected nothing, %s %0d conn %0d",
						$time, "actual status", res.status, res.out_conn_id);
					fail_count++;
				end else begin
					want = awaited_words[0];
					awaited_words.delete(0);
					check_field("status", want.conn, WORD_W'(want.status),
						WORD_W'(res.status));
					check_field("out_conn_id", want.conn, WORD_W'(want.conn),
						WORD_W'(res.out_conn_id));
					check_field("out_tag", want.conn, WORD_W'(want.tag),
						WORD_W'(res.out_tag));
					check_field("channel", want.conn, want.channel, res.channel);
					check_field("frame_length", want.conn, want.length, res.frame_length);
					check_field("payload_byte", want.conn, WORD_W'(want.pbyte),
						WORD_W'(res.payload_byte));
					check_field("first_of_frame", want.conn, WORD_W'(want.first),
						WORD_W'(res.first_of_frame));
					check_field("last_of_frame", want.conn, WORD_W'(want.last),
						WORD_W'(res.last_of_frame));
					check_field("source_id", want.conn, WORD_W'(want.src),
						WORD_W'(res.source_id));
				end
			end
		end
		pending = awaited_words.size();
	end

endmodule

// ===== verif/tb.sv =====
// deframer testbench top: clock, reset, event and config stimulus, result back-pressure
// depends on pcfd_pkg, pcfd_if.sv, the deframer RTL and pcfd_checker
`timescale 1ns / 100ps

module tb;
	import pcfd_pkg::*;

	localparam int NSLOT         = 8;
	localparam int RESET_CYCLES  = 6;
	localparam int PHASE_ITEMS   = 390;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 300000;

	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
	// ops that cannot open an idle entry
	localparam logic [OP_W-1:0] STRAY_OPS [6] = '{OP_READ, OP_EOF, OP_ERROR, OP_CONNECTED,
		OP_RSVD6, OP_RSVD7};

	typedef enum logic [1:0] {
		LINK_DOWN,
		LINK_PENDING,
		LINK_UP
	} link_state_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] data;
	} stream_item_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	int   sender_idle_pct = 0;
	int   sink_stall_pct = 0;
	bit   hold_req = 1'b0;

	logic [WORD_W-1:0] frame_limit_now = FRAME_LIMIT_RST;
	logic [CONN_W-1:0] slot_conn  [NSLOT];
	logic [TAG_W-1:0]  slot_tag   [NSLOT];
	link_state_t       link_state [NSLOT];
	bit                drop_after [NSLOT];
	stream_item_t      slot_q     [NSLOT][$];

	pcfd_evt_if evt_ch ();
	pcfd_res_if res_ch ();
	pcfd_cfg_if cfg_ch ();

	per_connection_frame_deframer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	pcfd_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// result back-pressure, with one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	function automatic bit in_pool(input logic [CONN_W-1:0] c, input int upto);
		for (int i = 0; i < upto; i++)
			if (slot_conn[i] == c) return 1'b1;
		return 1'b0;
	endfunction

	task automatic send_event(input logic [OP_W-1:0] op, input logic [CONN_W-1:0] c,
			input logic [TAG_W-1:0] t, input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.operation <= op;
		evt_ch.conn_id <= c;
		evt_ch.conn_tag <= t;
		evt_ch.data_byte <= b;
		do @(posedge clk); while (!evt_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_header(input logic [CONN_W-1:0] c, input logic [TAG_W-1:0] t,
			input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] chan);
		logic [2*WORD_W-1:0] hdr;
		hdr = {len, chan};
		for (int i = 7; i >= 0; i--) send_event(OP_READ, c, t, hdr[i*8 +: 8]);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [WORD_W-1:0] limit, input logic [SRC_W-1:0] id);
		write_reg(CFG_FRAME_LIMIT, limit);
		write_reg(CFG_PROCESSOR_ID, CFG_DATA_W'(id));
		cfg_ch.valid <= 1'b0;
		frame_limit_now = limit;
	endtask

	// wait for every expected word, then let words with no result drain out
	task automatic settle();
		evt_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic close_link(input int s);
		slot_q[s].delete();
		drop_after[s] = 1'b0;
		send_event($urandom_range(1) ? OP_EOF : OP_ERROR, slot_conn[s], slot_tag[s],
			BYTE_W'($urandom));
		link_state[s] = LINK_DOWN;
	endtask

	// header and payload of one frame; oversize frames close the entry after the header
	task automatic queue_frame(input int s);
		logic [WORD_W-1:0] len;
		logic [WORD_W-1:0] cap;
		logic [2*WORD_W-1:0] hdr;
		int kind;
		int tail;
		kind = $urandom_range(19);
		cap = (frame_limit_now < 12) ? frame_limit_now : 12;
		tail = 0;
		if (kind == 0) begin
			if (frame_limit_now == '1) begin
				// longest length is legal: a few bytes, then end of file
				len = '1;
				tail = $urandom_range(1, 4);
			end else begin
				len = (frame_limit_now > 32'hFFFF_FFF0) ? '1
					: frame_limit_now + WORD_W'($urandom_range(1, 4));
				drop_after[s] = 1'b1;
			end
		end else if (kind < 3 || cap == '0) begin
			len = '0;
		end else if (kind == 3 && frame_limit_now <= 40) begin
			len = frame_limit_now;
		end else begin
			len = $urandom_range(1, cap);
		end
		hdr = {len, WORD_W'($urandom)};
		for (int i = 7; i >= 0; i--) slot_q[s].push_back('{OP_READ, hdr[i*8 +: 8]});
		if (!drop_after[s]) begin
			for (int i = 0; i < ((tail > 0) ? tail : int'(len)); i++)
				slot_q[s].push_back('{OP_READ, BYTE_W'($urandom)});
			if (tail > 0) slot_q[s].push_back('{OP_EOF, BYTE_W'(0)});
		end
	endtask

	task automatic random_step(output bit counted);
		int s;
		int pick;
		stream_item_t it;
		logic [OP_W-1:0] op;
		logic [CONN_W-1:0] c;
		pick = $urandom_range(99);
		s = $urandom_range(NSLOT - 1);
		counted = 1'b1;
		if (pick < 85) begin
			case (link_state[s])
				LINK_DOWN: begin
					slot_tag[s] = TAG_W'($urandom);
					if ($urandom_range(3) == 0) begin
						send_event(OP_CONNECTING, slot_conn[s], slot_tag[s], BYTE_W'($urandom));
						link_state[s] = LINK_PENDING;
					end else begin
						send_event(OP_OPEN, slot_conn[s], slot_tag[s], BYTE_W'($urandom));
						link_state[s] = LINK_UP;
					end
				end
				LINK_PENDING: begin
					if ($urandom_range(3) == 0) begin
						send_event(OP_READ, slot_conn[s], slot_tag[s], BYTE_W'($urandom));
					end else begin
						send_event(OP_CONNECTED, slot_conn[s], slot_tag[s], BYTE_W'($urandom));
						link_state[s] = LINK_UP;
					end
				end
				default: begin
					if ($urandom_range(59) == 0
							|| (slot_q[s].size() == 0 && $urandom_range(7) == 0)) begin
						close_link(s);
					end else begin
						if (slot_q[s].size() == 0) queue_frame(s);
						it = slot_q[s][0];
						slot_q[s].delete(0);
						send_event(it.op, slot_conn[s], slot_tag[s], it.data);
						if (it.op != OP_READ) begin
							link_state[s] = LINK_DOWN;
						end else if (slot_q[s].size() == 0 && drop_after[s]) begin
							link_state[s] = LINK_DOWN;
							drop_after[s] = 1'b0;
						end
					end
				end
			endcase
		end else if (pick < 93) begin
			// wrong tag or wrong state: entry must stay as it is
			if (link_state[s] == LINK_DOWN) op = STRAY_OPS[$urandom_range(5)];
			else op = OP_W'($urandom);
			send_event(op, slot_conn[s], slot_tag[s] ^ TAG_W'($urandom_range(1, 65535)),
				BYTE_W'($urandom));
		end else begin
			do c = CONN_W'($urandom); while (in_pool(c, NSLOT));
			op = OP_W'($urandom);
			counted = (op != OP_READ);
			send_event(op, c, TAG_W'($urandom), BYTE_W'($urandom));
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input logic [WORD_W-1:0] limit,
			input logic [SRC_W-1:0] id, input bit squeeze);
		int done;
		bit counted;
		settle();
		set_config(limit, id);
		sender_idle_pct = idle;
		sink_stall_pct = stall;
		if (squeeze) hold_req = 1'b1;
		done = 0;
		while (done < PHASE_ITEMS) begin
			random_step(counted);
			done += counted;
		end
		for (int s = 0; s < NSLOT; s++)
			if (link_state[s] != LINK_DOWN) close_link(s);
	endtask

	initial begin
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.operation = OP_OPEN;
		evt_ch.conn_id = '0;
		evt_ch.conn_tag = '0;
		evt_ch.data_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_FRAME_LIMIT;
		cfg_ch.data = '0;
		slot_conn[0] = '0;
		slot_conn[1] = '1;
		slot_conn[2] = 10'h2AA;
		slot_conn[3] = 10'h155;
		for (int s = 4; s < NSLOT; s++) begin
			do slot_conn[s] = CONN_W'($urandom); while (in_pool(slot_conn[s], s));
		end
		for (int s = 0; s < NSLOT; s++) begin
			slot_tag[s] = '0;
			link_state[s] = LINK_DOWN;
			drop_after[s] = 1'b0;
		end
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset configuration
		send_event(OP_READ, 10'd5, 16'h1234, 8'hAA);       // idle entry: dropped
		send_event(OP_EOF, 10'd5, 16'h1234, 8'h00);        // idle entry: violation
		send_event(OP_RSVD6, 10'd5, 16'h0000, 8'h00);
		send_event(OP_OPEN, 10'd0, 16'hFFFF, 8'h00);
		send_event(OP_OPEN, 10'd0, 16'h0000, 8'h00);       // busy entry
		send_event(OP_READ, 10'd0, 16'h0000, 8'hFF);       // tag mismatch
		send_header(10'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF); // empty frame
		send_event(OP_CONNECTED, 10'd0, 16'hFFFF, 8'h00);  // not connecting
		send_event(OP_ERROR, 10'd0, 16'hFFFF, 8'h00);
		send_event(OP_CONNECTING, 10'd1023, 16'h0000, 8'h00);
		send_event(OP_READ, 10'd1023, 16'h0000, 8'h55);    // dropped while connecting
		send_event(OP_CONNECTED, 10'd1023, 16'h0001, 8'h00);
		send_event(OP_CONNECTED, 10'd1023, 16'h0000, 8'h00);
		send_header(10'd1023, 16'h0000, FRAME_LIMIT_RST + 1, 32'h1234_5678);

		run_phase(0, 0, 32'hFFFF_FFFF, 4'hF, 1'b1);
		run_phase(60, 0, 32'd0, 4'h0, 1'b0);
		run_phase(0, 60, 32'd20, SRC_W'($urandom), 1'b0);
		run_phase(36, 36, FRAME_LIMIT_RST, SRC_W'($urandom), 1'b0);
		settle();

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== per_connection_frame_deframer.f =====
+incdir+sv
sv/pcfd_pkg.sv
sv/pcfd_if.sv
sv/pcfd_ram.sv
sv/pcfd_front.sv
sv/pcfd_back.sv
sv/per_connection_frame_deframer.sv
sv/pcfd_checker.sv
verif/pcfd_checker.sv
verif/tb.sv
